// ----- hdl/array_insert_and_statistics_unit_defines.svh -----
// Assertion macros shared by the unit
`ifndef ARRAY_INSERT_AND_STATISTICS_UNIT_DEFINES_SVH
`define ARRAY_INSERT_AND_STATISTICS_UNIT_DEFINES_SVH

// check a property on every clock edge outside reset
`define AISU_ASSERT(name, clk, rst, prop) name: assert property (@(posedge clk) \
   disable iff (rst) prop) else $error("aisu: property failed");

// flag a condition that must never be seen outside reset
`define AISU_ASSERT_NEVER(name, clk, rst, cond) name: assert property (@(posedge clk) \
   disable iff (rst) !(cond)) else $error("aisu: forbidden condition seen");

`endif

// ----- hdl/aisu_pkg.sv -----
package aisu_pkg;

   localparam int DATA_W = 32;
   localparam int LEN_W  = 8;
   localparam int X_W    = 17;
   localparam int SQ_W   = 34;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] value;
      logic signed [31:0] position;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         length;
      logic signed [31:0] even_sum;
      logic signed [31:0] min_value;
      logic signed [31:0] max_value;
      logic signed [31:0] prime_sum;
      logic [7:0]         key_count;
      logic signed [31:0] read_data;
   } rsp_word_type;

   typedef struct packed {
      logic ld_req;
      logic clr;
      logic sh_rd;
      logic sh_wr;
      logic ins_wr;
      logic q_init;
      logic q_rd;
      logic q_load;
      logic p_step;
      logic p_add;
      logic div_start;
      logic q_next;
      logic rd_rd;
      logic done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       rd_oob;
      logic       shift_done;
      logic       q_last;
      logic       e_small;
      logic       sq_gt;
      logic       div_done;
      logic       rem_zero;
   } ctrl_sts_type;

endpackage

// ----- hdl/array_insert_and_statistics_unit.sv -----
// Ordered list of up to CAPACITY signed 32-bit words with clear, insert, query and read.
// A word is taken when start is high and busy is low; its single result appears on
// rsp_word for exactly one cycle with rsp_valid high, and the receiver cannot stall it.
// Clear goes from dispatch straight to the response, and read reads its entry first;
// insert shifts the entries from length down to position up one at a time through the
// shift read and shift write states of the entry memory, then writes the new word. An
// insert into a full list, a read out of range and a query on an empty list go straight
// to the response. Query loads each entry and, for each entry of 2 or more, tries each
// trial divisor x with x*x at most the entry in the one-bit-per-cycle remainder unit.
// The next word may be started in the cycle its predecessor's result is shown.
module array_insert_and_statistics_unit #(
   parameter int CAPACITY = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  aisu_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   output aisu_pkg::rsp_word_type rsp_word
);
   import aisu_pkg::*;
   `include "array_insert_and_statistics_unit_defines.svh"

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   aisu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   aisu_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   `AISU_ASSERT(a_start_busy, clock, reset, start && !busy |=> busy)
   `AISU_ASSERT(a_rsp_idle, clock, reset, rsp_valid |-> !busy)
   `AISU_ASSERT_NEVER(a_wr_rd, clock, reset, (cmd.sh_wr || cmd.ins_wr) && cmd.done)

endmodule

// ----- hdl/aisu_div.sv -----
module aisu_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [aisu_pkg::DATA_W-1:0] dividend,
   input  logic [aisu_pkg::X_W-1:0]    divisor,
   output logic                        done,
   output logic                        rem_zero
);
   import aisu_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [X_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0] num_ff, num_in;
   logic [X_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      trial   = {rem_ff, num_ff[DATA_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         num_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = X_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = X_W'(trial);
         end
         num_in = {num_ff[DATA_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

// ----- hdl/aisu_dp.sv -----
module aisu_dp #(
   parameter int CAPACITY = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  aisu_pkg::req_word_type req_word,
   input  aisu_pkg::ctrl_cmd_type cmd,
   output aisu_pkg::ctrl_sts_type sts,
   output logic                   rsp_valid,
   output aisu_pkg::rsp_word_type rsp_word
);
   import aisu_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rdata_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     waddr, raddr;
   logic [DATA_W-1:0] wdata;

   logic [1:0]        op_ff;
   logic [DATA_W-1:0] value_ff, pos_ff, e_ff;
   logic              full_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in, at_ff, at_in, key_ff, idx_m1;
   logic [DATA_W-1:0] even_ff, prime_ff, mn_ff, mx_ff;
   logic [X_W-1:0]    x_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_ff, rsp_in;
   logic              pos_big, empty, rd_oob, div_done, rem_zero;

   assign idx_m1  = idx_ff - CW'(1);
   assign pos_big = req_word.position > DATA_W'(count_ff);
   assign empty   = (count_ff == '0);
   assign rd_oob  = pos_ff[DATA_W-1] || (pos_ff >= DATA_W'(count_ff));

   always_comb begin
      if (req_word.position[DATA_W-1]) begin
         at_in = '0;
      end else if (pos_big) begin
         at_in = count_ff;
      end else begin
         at_in = CW'(req_word.position);
      end
   end

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (cmd.clr) count_in = '0;
      if (cmd.ins_wr) count_in = count_ff + CW'(1);
      if (cmd.ld_req) idx_in = count_ff;
      if (cmd.sh_wr) idx_in = idx_m1;
      if (cmd.q_init) idx_in = '0;
      if (cmd.q_next) idx_in = idx_ff + CW'(1);
   end

   always_comb begin
      mem_we = cmd.sh_wr || cmd.ins_wr;
      mem_re = cmd.sh_rd || cmd.q_rd || cmd.rd_rd;
      waddr  = cmd.ins_wr ? at_ff[AW-1:0] : idx_ff[AW-1:0];
      wdata  = cmd.ins_wr ? value_ff : rdata_ff;
      if (cmd.sh_rd) begin
         raddr = idx_m1[AW-1:0];
      end else if (cmd.rd_rd) begin
         raddr = pos_ff[AW-1:0];
      end else begin
         raddr = idx_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      if (mem_re) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         op_ff    <= req_word.op;
         value_ff <= req_word.value;
         pos_ff   <= req_word.position;
         at_ff    <= at_in;
         full_ff  <= (count_ff >= CW'(CAPACITY));
      end
      if (cmd.q_init) begin
         even_ff  <= '0;
         prime_ff <= '0;
         key_ff   <= '0;
      end
      if (cmd.q_load) begin
         e_ff  <= rdata_ff;
         x_ff  <= X_W'(2);
         sq_ff <= SQ_W'(4);
         if (!rdata_ff[0]) even_ff <= even_ff + rdata_ff;
         if (rdata_ff == value_ff) key_ff <= key_ff + CW'(1);
         if (idx_ff == '0 || $signed(rdata_ff) < $signed(mn_ff)) mn_ff <= rdata_ff;
         if (idx_ff == '0 || $signed(rdata_ff) > $signed(mx_ff)) mx_ff <= rdata_ff;
      end
      if (cmd.p_step) begin
         x_ff  <= x_ff + X_W'(1);
         sq_ff <= sq_ff + SQ_W'({x_ff, 1'b1});
      end
      if (cmd.p_add) prime_ff <= prime_ff + e_ff;
   end

   aisu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (e_ff),
      .divisor  (x_ff),
      .done     (div_done),
      .rem_zero (rem_zero)
   );

   always_comb begin
      rsp_in        = '0;
      rsp_in.length = LEN_W'(count_ff);
      unique case (op_ff)
         OP_CLEAR: rsp_in.status = ST_OK;
         OP_INSERT: rsp_in.status = full_ff ? ST_FULL : ST_OK;
         OP_QUERY: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.even_sum  = even_ff;
               rsp_in.prime_sum = prime_ff;
               rsp_in.min_value = mn_ff;
               rsp_in.max_value = mx_ff;
               rsp_in.key_count = LEN_W'(key_ff);
            end
         end
         OP_READ: begin
            if (rd_oob) rsp_in.status = ST_RANGE;
            else rsp_in.read_data = rdata_ff;
         end
         default: rsp_in.status = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= cmd.done;
      end
      if (cmd.done) rsp_ff <= rsp_in;
   end

   always_comb begin
      sts            = '0;
      sts.op         = op_ff;
      sts.full       = full_ff;
      sts.empty      = empty;
      sts.rd_oob     = rd_oob;
      sts.shift_done = (idx_ff == at_ff);
      sts.q_last     = (idx_ff + CW'(1) == count_ff);
      sts.e_small    = ($signed(e_ff) < $signed(DATA_W'(2)));
      sts.sq_gt      = (sq_ff > SQ_W'(e_ff));
      sts.div_done   = div_done;
      sts.rem_zero   = rem_zero;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- hdl/aisu_ctrl.sv -----
module aisu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  aisu_pkg::ctrl_sts_type sts,
   output aisu_pkg::ctrl_cmd_type cmd,
   output logic                   busy
);
   import aisu_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_SH_CHK   = 4'd2;
   localparam logic [3:0] S_SH_WR    = 4'd3;
   localparam logic [3:0] S_INS      = 4'd4;
   localparam logic [3:0] S_Q_RD     = 4'd5;
   localparam logic [3:0] S_Q_LD     = 4'd6;
   localparam logic [3:0] S_P_TEST   = 4'd7;
   localparam logic [3:0] S_P_DIV    = 4'd8;
   localparam logic [3:0] S_Q_NEXT   = 4'd9;
   localparam logic [3:0] S_RD_RD    = 4'd10;
   localparam logic [3:0] S_RESP     = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.ld_req = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.op)
               OP_CLEAR: begin
                  cmd.clr  = 1'b1;
                  state_in = S_RESP;
               end
               OP_INSERT: state_in = sts.full ? S_RESP : S_SH_CHK;
               OP_QUERY: begin
                  if (sts.empty) begin
                     state_in = S_RESP;
                  end else begin
                     cmd.q_init = 1'b1;
                     state_in   = S_Q_RD;
                  end
               end
               default: state_in = sts.rd_oob ? S_RESP : S_RD_RD;
            endcase
         end
         S_SH_CHK: begin
            if (sts.shift_done) begin
               state_in = S_INS;
            end else begin
               cmd.sh_rd = 1'b1;
               state_in  = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.sh_wr = 1'b1;
            state_in  = S_SH_CHK;
         end
         S_INS: begin
            cmd.ins_wr = 1'b1;
            state_in   = S_RESP;
         end
         S_Q_RD: begin
            cmd.q_rd = 1'b1;
            state_in = S_Q_LD;
         end
         S_Q_LD: begin
            cmd.q_load = 1'b1;
            state_in   = S_P_TEST;
         end
         S_P_TEST: begin
            if (sts.e_small) begin
               state_in = S_Q_NEXT;
            end else if (sts.sq_gt) begin
               cmd.p_add = 1'b1;
               state_in  = S_Q_NEXT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_P_DIV;
            end
         end
         S_P_DIV: begin
            if (sts.div_done) begin
               if (sts.rem_zero) begin
                  state_in = S_Q_NEXT;
               end else begin
                  cmd.p_step = 1'b1;
                  state_in   = S_P_TEST;
               end
            end
         end
         S_Q_NEXT: begin
            if (sts.q_last) begin
               state_in = S_RESP;
            end else begin
               cmd.q_next = 1'b1;
               state_in   = S_Q_RD;
            end
         end
         S_RD_RD: begin
            cmd.rd_rd = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            cmd.done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
